// ----- src/crc_gb_pkg.sv -----
`default_nettype none

package crc_gb_pkg;

  localparam int unsigned CrcW     = 32;
  localparam int unsigned CfgWidW  = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned EffWidW  = 7;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [CfgWidW-1:0] WidthReset = 6'd8;
  localparam logic [CrcW-1:0]    PolyReset  = 32'd7;

  typedef enum logic {
    REG_CRC_WIDTH = 1'b0,
    REG_POLY_LOW  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CfgWidW-1:0] crc_width;
    logic [CrcW-1:0]    poly_low;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/crc_gb_step.sv -----
`default_nettype none

module crc_gb_step #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  crc_gb_pkg::cfg_t                  cfg_i,
  input  logic [crc_gb_pkg::CrcW-1:0]       rem_i,
  input  logic [crc_gb_pkg::ByteW-1:0]      data_byte_i,
  output logic [crc_gb_pkg::CrcW-1:0]       rem_o,
  output logic                              zero_o
);

  localparam int unsigned RemW = MAX_WIDTH;
  localparam int unsigned IdxW = (RemW > 1) ? $clog2(RemW) : 1;

  logic [crc_gb_pkg::EffWidW-1:0] wid_raw;
  logic [crc_gb_pkg::EffWidW-1:0] wid_eff;
  logic [IdxW-1:0]                top_idx;
  logic [RemW-1:0]                mask;
  logic [RemW-1:0]                rem_ext;
  logic [RemW-1:0]                poly_ext;
  logic [RemW-1:0]                poly;
  logic [RemW-1:0]                rem_run;
  logic                           fb;

  for (genvar i = 0; i < RemW; i++) begin : g_ext
    if (i < crc_gb_pkg::CrcW) begin : g_in
      assign rem_ext[i]  = rem_i[i];
      assign poly_ext[i] = cfg_i.poly_low[i];
    end else begin : g_zero
      assign rem_ext[i]  = 1'b0;
      assign poly_ext[i] = 1'b0;
    end
  end

  always_comb begin
    wid_raw = {1'b0, cfg_i.crc_width};
    if (wid_raw == '0) begin
      wid_eff = crc_gb_pkg::EffWidW'(1);
    end else if (wid_raw > crc_gb_pkg::EffWidW'(MAX_WIDTH)) begin
      wid_eff = crc_gb_pkg::EffWidW'(MAX_WIDTH);
    end else begin
      wid_eff = wid_raw;
    end
    top_idx = IdxW'(wid_eff - crc_gb_pkg::EffWidW'(1));
    for (int i = 0; i < RemW; i++) begin
      mask[i] = (crc_gb_pkg::EffWidW'(i) < wid_eff);
    end
    poly    = poly_ext & mask;
    rem_run = rem_ext & mask;
    for (int b = crc_gb_pkg::ByteW - 1; b >= 0; b--) begin
      fb      = rem_run[top_idx] ^ data_byte_i[b];
      rem_run = (rem_run << 1) & mask;
      if (fb) begin
        rem_run = rem_run ^ poly;
      end
    end
  end

  for (genvar i = 0; i < crc_gb_pkg::CrcW; i++) begin : g_out
    if (i < RemW) begin : g_bit
      assign rem_o[i] = rem_run[i];
    end else begin : g_zero
      assign rem_o[i] = 1'b0;
    end
  end

  assign zero_o = (rem_run == '0);

endmodule

`default_nettype wire

// ----- src/crc_generic_bitwise.sv -----
// Configurable CRC generator and checker, message bits taken MSB first.
// The input stream carries one message byte per word in s_axis_tdata, and
// s_axis_tlast marks the final byte of a message. Bytes without tlast only
// advance the running remainder and give no output word.
// On the final byte one output word appears: m_axis_tdata holds the
// remainder (low crc_width bits valid), and m_axis_tuser is high when the
// remainder is zero, which is the pass flag when checking a message that
// carries its own CRC. The remainder then clears for the next message.
// The output word is registered and appears in the cycle after the accepted final byte.
// Throughput is one byte per cycle: the eight shift-and-XOR steps of a
// byte sit between the input handshake and the remainder register.
// When the receiver stalls, the output register holds its word and input
// is accepted again in the cycle the word is taken.
// Reset clears the remainder and output valid, sets crc_width to 8 and
// poly_low to 7. The APB port writes crc_width at 0x0 and poly_low at 0x4
// and should only be written while no message is in progress.
`default_nettype none

module crc_generic_bitwise #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Bits 7:0 data_byte.
  input  logic [crc_gb_pkg::ByteW-1:0]       s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Bits 31:0 crc_value.
  output logic [crc_gb_pkg::CrcW-1:0]        m_axis_tdata,
  // Bit 0 remainder_zero.
  output logic                               m_axis_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [crc_gb_pkg::ApbAddrW-1:0]    paddr,
  input  logic [crc_gb_pkg::ApbDataW-1:0]    pwdata,
  output logic [crc_gb_pkg::ApbDataW-1:0]    prdata,
  output logic                               pready
);

  crc_gb_pkg::cfg_t              cfg_q;
  logic [crc_gb_pkg::CrcW-1:0]   rem_q;
  logic [crc_gb_pkg::CrcW-1:0]   rem_d;
  logic                          zero_d;
  logic                          out_valid_q;
  logic [crc_gb_pkg::CrcW-1:0]   out_crc_q;
  logic                          out_zero_q;
  logic                          in_acc;
  logic                          cfg_wr;
  crc_gb_pkg::reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = crc_gb_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    case (reg_idx)
      crc_gb_pkg::REG_CRC_WIDTH:
        prdata = crc_gb_pkg::ApbDataW'(cfg_q.crc_width);
      crc_gb_pkg::REG_POLY_LOW:
        prdata = cfg_q.poly_low;
      default:
        prdata = '0;
    endcase
  end

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  crc_gb_step #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_step (
    .cfg_i      (cfg_q),
    .rem_i      (rem_q),
    .data_byte_i(s_axis_tdata),
    .rem_o      (rem_d),
    .zero_o     (zero_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_width <= crc_gb_pkg::WidthReset;
      cfg_q.poly_low  <= crc_gb_pkg::PolyReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        crc_gb_pkg::REG_CRC_WIDTH:
          cfg_q.crc_width <= pwdata[crc_gb_pkg::CfgWidW-1:0];
        crc_gb_pkg::REG_POLY_LOW:
          cfg_q.poly_low  <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        rem_q       <= '0;
        out_valid_q <= 1'b1;
      end else begin
        rem_q       <= rem_d;
        out_valid_q <= 1'b0;
      end
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      out_crc_q  <= rem_d;
      out_zero_q <= zero_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_crc_q;
  assign m_axis_tuser  = out_zero_q;

  a_last_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> m_axis_tvalid)
    else $error("final byte accepted without an output word");

  a_last_clears_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (rem_q == '0))
    else $error("remainder not cleared after final byte");

  a_flag_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (MAX_WIDTH <= crc_gb_pkg::CrcW && m_axis_tvalid) |->
      (m_axis_tuser == (m_axis_tdata == '0)))
    else $error("zero flag disagrees with remainder");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output word stalled");

endmodule

`default_nettype wire
